[hw/rtl/tti_pkg.sv]
// Package for the trilinear table interpolator: request and response types,
// register and command codes, store geometry and the blend arithmetic.
// No dependencies.
package tti_pkg;

   localparam int STORE_AW    = 15;
   localparam int STORE_DEPTH = 1 << STORE_AW;
   localparam int CELL_W      = 9;   // holds any cell index up to 511
   localparam int WEIGHT_W    = 17;  // Q0.16 weight plus the value one
   localparam int NUM_BANKS   = 8;
   localparam int RSP_DEPTH   = 16;

   localparam int DEF_RADIUS_POINTS     = 16;
   localparam int DEF_WAVELENGTH_POINTS = 32;
   localparam int DEF_ANGLE_POINTS      = 64;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      REG_RADIUS_START     = 3'd0,
      REG_RADIUS_INV_STEP  = 3'd1,
      REG_WAVE_START       = 3'd2,
      REG_WAVE_INV_STEP    = 3'd3,
      REG_ANGLE_START      = 3'd4,
      REG_ANGLE_INV_STEP   = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic               cmd;
      logic [14:0]        entry_addr;
      logic signed [31:0] entry_value;
      logic signed [31:0] radius_coord;
      logic signed [31:0] wavelength_coord;
      logic signed [31:0] angle_coord;
   } req_type;

   typedef struct packed {
      logic signed [31:0] interp_value;
      logic               range_error;
   } rsp_type;

   // a*(1-w) + b*w in Q16 weights, rounded half up, written as
   // a*65536 + (b-a)*w so that one multiplier does the work.
   function automatic logic signed [31:0] blend(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                input logic [WEIGHT_W-1:0] w);
      logic signed [32:0] d;
      logic signed [51:0] prod;
      logic signed [51:0] sum;
      d    = 33'(b) - 33'(a);
      prod = 52'(d * $signed({1'b0, w}));
      sum  = (52'(a) <<< 16) + prod + 52'sd32768;
      blend = sum[47:16];
   endfunction

endpackage

[hw/rtl/trilinear_table_interpolator.sv]
// Top level of the trilinear table interpolator: eight replicated table
// memories read in parallel, locate and blend pipeline, response queue.
// Depends on tti_pkg.
//
// Channel  Dir  Handshake              Carries
// req      in   req_valid/req_ready    tti_pkg::req_type (write or query)
// rsp      out  rsp_valid/rsp_ready    tti_pkg::rsp_type (one per query)
// csr      in   csr_valid/csr_ready    register index and write data
//
// One request is taken every cycle while credits remain; a query's response
// passes the subtract, multiply, locate, memory read and blend stages and
// the response queue. The pipeline never stalls: a credit counter stops
// requests only when sixteen responses are in flight or queued.
// Reset is synchronous and clears control state and registers; the table
// contents are undefined until written.
module trilinear_table_interpolator #(
   parameter int RADIUS_POINTS     = tti_pkg::DEF_RADIUS_POINTS,
   parameter int WAVELENGTH_POINTS = tti_pkg::DEF_WAVELENGTH_POINTS,
   parameter int ANGLE_POINTS      = tti_pkg::DEF_ANGLE_POINTS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tti_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tti_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_wdata
);
   import tti_pkg::*;

   localparam int CNT_W = $clog2(RSP_DEPTH) + 1;
   localparam int PTR_W = $clog2(RSP_DEPTH);

   // Configuration registers.
   logic signed [31:0] start_ff [3];
   logic [31:0]        inv_ff [3];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            start_ff[i] <= '0;
            inv_ff[i]   <= 32'd65536;
         end
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_RADIUS_START:    start_ff[0] <= csr_wdata;
            REG_RADIUS_INV_STEP: inv_ff[0]   <= csr_wdata;
            REG_WAVE_START:      start_ff[1] <= csr_wdata;
            REG_WAVE_INV_STEP:   inv_ff[1]   <= csr_wdata;
            REG_ANGLE_START:     start_ff[2] <= csr_wdata;
            REG_ANGLE_INV_STEP:  inv_ff[2]   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Credit counter over responses in flight or queued.
   logic [CNT_W-1:0] credit_ff, credit_in;
   logic             req_fire, rsp_fire, query_fire;

   assign req_ready  = (credit_ff < CNT_W'(RSP_DEPTH));
   assign req_fire   = req_valid && req_ready;
   assign query_fire = req_fire && (req_data.cmd == CMD_QUERY);
   assign rsp_fire   = rsp_valid && rsp_ready;

   always_comb begin
      credit_in = credit_ff + CNT_W'(query_fire) - CNT_W'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) credit_ff <= '0;
      else       credit_ff <= credit_in;
   end

   // Stage 1: accepted request.
   logic    s1_vld_ff;
   req_type s1_req_ff;

   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else       s1_vld_ff <= req_fire;
      s1_req_ff <= req_data;
   end

   // Stage 2: coordinate minus start.
   logic               s2_vld_ff;
   logic               s2_cmd_ff;
   logic [14:0]        s2_addr_ff;
   logic [31:0]        s2_val_ff;
   logic signed [32:0] s2_diff_ff [3];

   always_ff @(posedge clock) begin
      if (reset) s2_vld_ff <= 1'b0;
      else       s2_vld_ff <= s1_vld_ff;
      s2_cmd_ff     <= s1_req_ff.cmd;
      s2_addr_ff    <= s1_req_ff.entry_addr;
      s2_val_ff     <= s1_req_ff.entry_value;
      s2_diff_ff[0] <= 33'(s1_req_ff.radius_coord) - 33'(start_ff[0]);
      s2_diff_ff[1] <= 33'(s1_req_ff.wavelength_coord) - 33'(start_ff[1]);
      s2_diff_ff[2] <= 33'(s1_req_ff.angle_coord) - 33'(start_ff[2]);
   end

   // Stage 3: grid position in Q32.32, one multiplier per axis.
   logic        s3_vld_ff, s3_cmd_ff;
   logic [14:0] s3_addr_ff;
   logic [31:0] s3_val_ff;
   logic [63:0] s3_pos_ff [3];
   logic        s3_neg_ff [3];
   logic        s3_zinv_ff [3];

   always_ff @(posedge clock) begin
      if (reset) s3_vld_ff <= 1'b0;
      else       s3_vld_ff <= s2_vld_ff;
      s3_cmd_ff  <= s2_cmd_ff;
      s3_addr_ff <= s2_addr_ff;
      s3_val_ff  <= s2_val_ff;
      for (int i = 0; i < 3; i++) begin
         s3_pos_ff[i]  <= s2_diff_ff[i][31:0] * inv_ff[i];
         s3_neg_ff[i]  <= s2_diff_ff[i][32];
         s3_zinv_ff[i] <= (inv_ff[i] == '0);
      end
   end

   // Stage 4: cell index, weight and range check per axis.
   logic [31:0]         last_idx [3];
   logic [CELL_W-1:0]   cell_in [3];
   logic [WEIGHT_W-1:0] wt_in [3];
   logic                err_in [3];

   assign last_idx[0] = 32'(RADIUS_POINTS - 1);
   assign last_idx[1] = 32'(WAVELENGTH_POINTS - 1);
   assign last_idx[2] = 32'(ANGLE_POINTS - 1);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cell_in[i] = '0;
         wt_in[i]   = '0;
         err_in[i]  = 1'b0;
         priority if (s3_zinv_ff[i]) begin
            err_in[i] = 1'b0;
         end else if (s3_neg_ff[i] || (s3_pos_ff[i][63:32] > last_idx[i])) begin
            err_in[i] = 1'b1;
         end else if (s3_pos_ff[i][63:32] == last_idx[i]) begin
            // Exactly on the top grid point: last cell at full weight.
            err_in[i]  = (s3_pos_ff[i][31:0] != '0);
            cell_in[i] = CELL_W'(last_idx[i] - 32'd1);
            wt_in[i]   = WEIGHT_W'(65536);
         end else begin
            cell_in[i] = s3_pos_ff[i][32+CELL_W-1:32];
            wt_in[i]   = {1'b0, s3_pos_ff[i][31:16]};
         end
      end
   end

   logic                s4_vld_ff, s4_cmd_ff;
   logic [14:0]         s4_addr_ff;
   logic [31:0]         s4_val_ff;
   logic [CELL_W-1:0]   s4_cell_ff [3];
   logic [WEIGHT_W-1:0] s4_wt_ff [3];
   logic                s4_err_ff;

   always_ff @(posedge clock) begin
      if (reset) s4_vld_ff <= 1'b0;
      else       s4_vld_ff <= s3_vld_ff;
      s4_cmd_ff  <= s3_cmd_ff;
      s4_addr_ff <= s3_addr_ff;
      s4_val_ff  <= s3_val_ff;
      s4_cell_ff <= cell_in;
      s4_wt_ff   <= wt_in;
      s4_err_ff  <= err_in[0] || err_in[1] || err_in[2];
   end

   // Neighbor addresses; bank b reads corner (b[2], b[1], b[0]) offsets
   // in radius, wavelength and angle.
   logic [STORE_AW-1:0] rd_addr [NUM_BANKS];

   always_comb begin
      logic [31:0] r, l, a;
      for (int b = 0; b < NUM_BANKS; b++) begin
         r = 32'(s4_cell_ff[0]) + 32'(b[2]);
         l = 32'(s4_cell_ff[1]) + 32'(b[1]);
         a = 32'(s4_cell_ff[2]) + 32'(b[0]);
         rd_addr[b] = STORE_AW'((r * 32'(WAVELENGTH_POINTS) + l) * 32'(ANGLE_POINTS) + a);
      end
   end

   // Table memories, one copy per corner. Writes go through the same stage
   // as reads, so program order between writes and queries holds.
   logic [31:0] bank_mem [NUM_BANKS][STORE_DEPTH];
   logic [31:0] rd_data_ff [NUM_BANKS];
   logic        bank_we;

   assign bank_we = s4_vld_ff && (s4_cmd_ff == CMD_WRITE);

   always_ff @(posedge clock) begin
      for (int b = 0; b < NUM_BANKS; b++) begin
         if (bank_we) bank_mem[b][s4_addr_ff] <= s4_val_ff;
         rd_data_ff[b] <= bank_mem[b][rd_addr[b]];
      end
   end

   // Stage 5: memory data; blend along angle.
   logic                s5_vld_ff, s5_err_ff;
   logic [WEIGHT_W-1:0] s5_wt_ff [3];

   always_ff @(posedge clock) begin
      if (reset) s5_vld_ff <= 1'b0;
      else       s5_vld_ff <= s4_vld_ff && (s4_cmd_ff == CMD_QUERY);
      s5_err_ff <= s4_err_ff;
      s5_wt_ff  <= s4_wt_ff;
   end

   // Stage 6: angle blends; blend along wavelength.
   logic                s6_vld_ff, s6_err_ff;
   logic [WEIGHT_W-1:0] s6_wt_ff [2];
   logic signed [31:0]  s6_c_ff [4];

   always_ff @(posedge clock) begin
      if (reset) s6_vld_ff <= 1'b0;
      else       s6_vld_ff <= s5_vld_ff;
      s6_err_ff   <= s5_err_ff;
      s6_wt_ff[0] <= s5_wt_ff[0];
      s6_wt_ff[1] <= s5_wt_ff[1];
      for (int j = 0; j < 4; j++) begin
         s6_c_ff[j] <= blend(rd_data_ff[2*j], rd_data_ff[2*j+1], s5_wt_ff[2]);
      end
   end

   // Stage 7: wavelength blends; blend along radius.
   logic                s7_vld_ff, s7_err_ff;
   logic [WEIGHT_W-1:0] s7_wt_ff;
   logic signed [31:0]  s7_d_ff [2];
   logic signed [31:0]  final_value;

   always_ff @(posedge clock) begin
      if (reset) s7_vld_ff <= 1'b0;
      else       s7_vld_ff <= s6_vld_ff;
      s7_err_ff  <= s6_err_ff;
      s7_wt_ff   <= s6_wt_ff[0];
      s7_d_ff[0] <= blend(s6_c_ff[0], s6_c_ff[1], s6_wt_ff[1]);
      s7_d_ff[1] <= blend(s6_c_ff[2], s6_c_ff[3], s6_wt_ff[1]);
   end

   assign final_value = s7_err_ff ? 32'sd0 : blend(s7_d_ff[0], s7_d_ff[1], s7_wt_ff);

   // Response queue; credits guarantee it never overflows.
   rsp_type          rsp_q_ff [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] q_cnt_ff;

   always_ff @(posedge clock) begin
      if (s7_vld_ff) begin
         rsp_q_ff[wr_ptr_ff].interp_value <= final_value;
         rsp_q_ff[wr_ptr_ff].range_error  <= s7_err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         q_cnt_ff  <= '0;
      end else begin
         if (s7_vld_ff) wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         if (rsp_fire)  rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         q_cnt_ff <= q_cnt_ff + CNT_W'(s7_vld_ff) - CNT_W'(rsp_fire);
      end
   end

   assign rsp_valid = (q_cnt_ff != '0);
   assign rsp_data  = rsp_q_ff[rd_ptr_ff];

   // Checks on credits and queue.
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CNT_W'(RSP_DEPTH)) else $error("credit counter overran");
   a_queue_within_credit: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff <= credit_ff) else $error("queue holds more than its credits");
   a_rsp_needs_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (credit_ff != '0)) else $error("response without credit");

endmodule
